>>> rtl/core/frt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package frt_pkg;

   // Default sizing
   localparam int SLOTS_DEF         = 8;
   localparam int MAX_FRAGMENTS_DEF = 64;

   // Register reset values
   localparam logic [23:0] BUDGET_RST  = 24'd4194304;
   localparam logic [15:0] TIMEOUT_RST = 16'd1000;

   // Register indexes
   localparam logic [7:0] CSR_BUDGET  = 8'd0;
   localparam logic [7:0] CSR_TIMEOUT = 8'd1;

   // Item kinds
   localparam logic CMD_FRAG = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_TICK     = 3'd0;
   localparam logic [2:0] ST_REJECT   = 3'd1;
   localparam logic [2:0] ST_PENDING  = 3'd2;
   localparam logic [2:0] ST_CONFLICT = 3'd3;
   localparam logic [2:0] ST_NOSPACE  = 3'd4;
   localparam logic [2:0] ST_COMPLETE = 3'd5;

   typedef struct packed {
      logic        cmd;
      logic        header_ok;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic [15:0] sequence_req;
      logic [15:0] frag_num;
      logic [31:0] whole_size;
      logic [15:0] declared_size;
      logic [15:0] payload_len;
      logic [31:0] payload_digest;
   } item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  slot_index;
      logic [23:0] message_size;
      logic [6:0]  frag_tally;
   } res_type;

   typedef struct packed {
      logic [23:0] reassembly_budget;
      logic [15:0] fragment_timeout;
   } cfg_type;

endpackage
`default_nettype wire

>>> rtl/core/fragment_reassembly_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// Fragment reassembly tracker. Slot records live in a memory with one read port,
// scanned one record per cycle; fragment digests live in a second memory. A
// fragment passes an expiry/match scan over all slots, then check and write-back,
// plus a further record scan for each slot evicted to fit the byte budget. One
// item is in work at a time; a finished result waits in an output register so the
// next item can be taken. Configuration writes are taken every cycle.
module fragment_reassembly_tracker #(
   parameter int SLOTS         = frt_pkg::SLOTS_DEF,
   parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // header_ok, src_addr, src_port, sequence_req, frag_num, whole_size,
   // declared_size, payload_len, payload_digest (lowest bit up), zero pad
   input  wire logic [183:0] req_tdata,
   // cmd
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status, slot_index, message_size, frag_tally (lowest bit up), zero pad
   output logic [39:0]       rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   frt_pkg::item_type req_item;
   frt_pkg::cfg_type  cfg;
   frt_pkg::res_type  eng_res, out_res;
   logic              eng_valid, eng_ready;

   // Unpack the input transfer
   assign req_item.cmd            = req_tuser;
   assign req_item.header_ok      = req_tdata[0];
   assign req_item.src_addr       = req_tdata[32:1];
   assign req_item.src_port       = req_tdata[48:33];
   assign req_item.sequence_req   = req_tdata[64:49];
   assign req_item.frag_num       = req_tdata[80:65];
   assign req_item.whole_size     = req_tdata[112:81];
   assign req_item.declared_size  = req_tdata[128:113];
   assign req_item.payload_len    = req_tdata[144:129];
   assign req_item.payload_digest = req_tdata[176:145];

   // Pack the result transfer
   assign rsp_tdata = {3'd0, out_res.frag_tally, out_res.message_size,
                       out_res.slot_index, out_res.status};

   frt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   frt_engine #(
      .SLOTS         (SLOTS),
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req_item),
      .cfg       (cfg),
      .res_valid (eng_valid),
      .res_ready (eng_ready),
      .res       (eng_res)
   );

   frt_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (eng_valid),
      .in_ready  (eng_ready),
      .in_res    (eng_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

endmodule
`default_nettype wire

>>> rtl/core/frt_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module frt_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_index,
   input  wire logic [31:0]       csr_data,
   output frt_pkg::cfg_type       cfg
);

   frt_pkg::cfg_type cfg_ff, cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            frt_pkg::CSR_BUDGET:  cfg_in.reassembly_budget = csr_data[23:0];
            frt_pkg::CSR_TIMEOUT: cfg_in.fragment_timeout  = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reassembly_budget <= frt_pkg::BUDGET_RST;
         cfg_ff.fragment_timeout  <= frt_pkg::TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/frt_rsp_reg.sv
`timescale 1ns / 1ps
`default_nettype none
module frt_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire frt_pkg::res_type  in_res,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output frt_pkg::res_type       out_res
);

   logic             full_ff, full_in;
   frt_pkg::res_type data_ff;

   assign in_ready  = !full_ff || out_ready;
   assign out_valid = full_ff;
   assign out_res   = data_ff;

   // Occupancy
   always_comb begin
      full_in = full_ff;
      if (out_ready) full_in = 1'b0;
      if (in_valid && in_ready) full_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) data_ff <= in_res;
   end

endmodule
`default_nettype wire

>>> rtl/core/frt_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module frt_engine #(
   parameter int SLOTS         = frt_pkg::SLOTS_DEF,
   parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire frt_pkg::item_type  req,
   input  wire frt_pkg::cfg_type   cfg,
   output logic                    res_valid,
   input  wire logic               res_ready,
   output frt_pkg::res_type        res
);

   localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SCW  = $clog2(SLOTS + 1);
   localparam int FW   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int CW   = $clog2(MAX_FRAGMENTS + 1);
   localparam int DEP  = SLOTS * MAX_FRAGMENTS;
   localparam int DAW  = (DEP > 1) ? $clog2(DEP) : 1;
   localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_CHECK  = 4'd3;
   localparam logic [3:0] S_DIGCMP = 4'd4;
   localparam logic [3:0] S_BUDGET = 4'd5;
   localparam logic [3:0] S_BSCAN  = 4'd6;
   localparam logic [3:0] S_BDEC   = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   typedef struct packed {
      logic [31:0]              addr;
      logic [15:0]              port;
      logic [15:0]              seq;
      logic [23:0]              total;
      logic [23:0]              bytes;
      logic [31:0]              updated;
      logic [MAX_FRAGMENTS-1:0] present;
      logic [CW-1:0]            cnt;
      logic [FW-1:0]            maxid;
   } rec_type;

   function automatic logic [23:0] sat_sub(input logic [23:0] a, input logic [23:0] b);
      return (a >= b) ? (a - b) : 24'd0;
   endfunction

   // Slot records and fragment digests
   rec_type     slot_mem [SLOTS];
   logic [31:0] dig_mem  [DEP];

   logic [3:0]          state_ff, state_in;
   frt_pkg::item_type   itm_ff, itm_in;
   frt_pkg::res_type    res_ff, res_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [23:0]         used_ff, used_in;
   logic [31:0]         time_ff, time_in;
   rec_type             cur_ff, cur_in;
   logic [SW-1:0]       cur_idx_ff, cur_idx_in;
   logic [SCW-1:0]      rd_idx_ff, rd_idx_in;
   logic                pv_ff, pv_in;
   logic [SW-1:0]       pidx_ff, pidx_in;
   logic                match_fnd_ff, match_fnd_in;
   logic                free_fnd_ff, free_fnd_in;
   logic [SW-1:0]       free_idx_ff, free_idx_in;
   logic                old_fnd_ff, old_fnd_in;
   logic [SW-1:0]       old_idx_ff, old_idx_in;
   logic [31:0]         old_age_ff, old_age_in;
   logic [23:0]         old_bytes_ff, old_bytes_in;

   logic                mem_re, mem_we;
   logic [SW-1:0]       mem_ra;
   rec_type             mem_wd, mem_rd_ff;
   logic                dig_re, dig_we;
   logic [DAW-1:0]      dig_addr;
   logic [31:0]         dig_rd_ff;

   logic [FW-1:0]       fidx;
   logic                reject;

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;
   assign fidx      = itm_ff.frag_num[FW-1:0];
   assign dig_addr  = DAW'(cur_idx_ff) * DAW'(MAX_FRAGMENTS) + DAW'(fidx);

   // Header and size checks
   assign reject = !itm_ff.header_ok
                || (itm_ff.payload_len != itm_ff.declared_size)
                || ({16'd0, itm_ff.declared_size} > itm_ff.whole_size)
                || ((itm_ff.whole_size == 32'd0)
                    && ((itm_ff.frag_num != 16'd0) || (itm_ff.declared_size != 16'd0)))
                || ((itm_ff.whole_size != 32'd0) && (itm_ff.declared_size == 16'd0))
                || (itm_ff.whole_size > {8'd0, cfg.reassembly_budget})
                || ({16'd0, itm_ff.frag_num} >= 32'(MAX_FRAGMENTS));

   // Sequencer
   always_comb begin
      rec_type     r;
      logic [31:0] age;
      logic        v;
      logic        expd;
      logic        live;
      logic [24:0] sum;

      state_in     = state_ff;
      itm_in       = itm_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      time_in      = time_ff;
      cur_in       = cur_ff;
      cur_idx_in   = cur_idx_ff;
      rd_idx_in    = rd_idx_ff;
      pv_in        = 1'b0;
      pidx_in      = pidx_ff;
      match_fnd_in = match_fnd_ff;
      free_fnd_in  = free_fnd_ff;
      free_idx_in  = free_idx_ff;
      old_fnd_in   = old_fnd_ff;
      old_idx_in   = old_idx_ff;
      old_age_in   = old_age_ff;
      old_bytes_in = old_bytes_ff;
      mem_re       = 1'b0;
      mem_ra       = rd_idx_ff[SW-1:0];
      mem_we       = 1'b0;
      mem_wd       = cur_ff;
      dig_re       = 1'b0;
      dig_we       = 1'b0;
      r            = mem_rd_ff;
      age          = time_ff - mem_rd_ff.updated;
      v            = 1'b0;
      expd         = 1'b0;
      live         = 1'b0;
      sum          = {1'b0, cur_ff.bytes} + {9'd0, itm_ff.payload_len};

      // One record read issued per cycle while scanning
      if ((state_ff == S_SCAN || state_ff == S_BSCAN) && (rd_idx_ff < SCW'(SLOTS))) begin
         mem_re    = 1'b1;
         rd_idx_in = rd_idx_ff + SCW'(1);
         pv_in     = 1'b1;
         pidx_in   = rd_idx_ff[SW-1:0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               itm_in = req;
               if (req.cmd == frt_pkg::CMD_TICK) begin
                  time_in  = time_ff + 32'd1;
                  res_in   = '{frt_pkg::ST_TICK, 3'd0, 24'd0, 7'd0};
                  state_in = S_EMIT;
               end else begin
                  rd_idx_in    = '0;
                  match_fnd_in = 1'b0;
                  free_fnd_in  = 1'b0;
                  old_fnd_in   = 1'b0;
                  state_in     = S_SCAN;
               end
            end
         end

         // Expiry, key match, first free and oldest in one pass
         S_SCAN: begin
            if (pv_ff) begin
               v    = valid_ff[pidx_ff];
               expd = v && (age > {16'd0, cfg.fragment_timeout});
               live = v && !expd;
               if (expd) begin
                  valid_in[pidx_ff] = 1'b0;
                  used_in = sat_sub(used_ff, r.bytes);
               end
               if (live && !match_fnd_ff && (r.addr == itm_ff.src_addr)
                   && (r.port == itm_ff.src_port) && (r.seq == itm_ff.sequence_req)) begin
                  match_fnd_in = 1'b1;
                  cur_in       = r;
                  cur_idx_in   = pidx_ff;
               end
               if (!live && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_idx_in = pidx_ff;
               end
               if (live && (!old_fnd_ff || age > old_age_ff)) begin
                  old_fnd_in   = 1'b1;
                  old_idx_in   = pidx_ff;
                  old_age_in   = age;
                  old_bytes_in = r.bytes;
               end
               if (pidx_ff == LAST) state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            if (reject) begin
               res_in   = '{frt_pkg::ST_REJECT, 3'd0, 24'd0, 7'd0};
               state_in = S_EMIT;
            end else if (match_fnd_ff) begin
               if (cur_ff.total != itm_ff.whole_size[23:0]) begin
                  valid_in[cur_idx_ff] = 1'b0;
                  used_in  = sat_sub(used_ff, cur_ff.bytes);
                  res_in   = '{frt_pkg::ST_CONFLICT, 3'(cur_idx_ff), 24'd0, 7'd0};
                  state_in = S_EMIT;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               // New key: lowest free slot, else evict the oldest
               if (free_fnd_ff) begin
                  cur_idx_in = free_idx_ff;
               end else begin
                  cur_idx_in = old_idx_ff;
                  used_in    = sat_sub(used_ff, old_bytes_ff);
               end
               valid_in[cur_idx_in] = 1'b1;
               cur_in.addr    = itm_ff.src_addr;
               cur_in.port    = itm_ff.src_port;
               cur_in.seq     = itm_ff.sequence_req;
               cur_in.total   = itm_ff.whole_size[23:0];
               cur_in.bytes   = 24'd0;
               cur_in.updated = time_ff;
               cur_in.present = '0;
               cur_in.cnt     = '0;
               cur_in.maxid   = '0;
               state_in       = S_CHECK;
            end
         end

         S_CHECK: begin
            if (cur_ff.present[fidx]) begin
               dig_re   = 1'b1;
               state_in = S_DIGCMP;
            end else if (sum > {1'b0, cur_ff.total}) begin
               valid_in[cur_idx_ff] = 1'b0;
               used_in  = sat_sub(used_ff, cur_ff.bytes);
               res_in   = '{frt_pkg::ST_CONFLICT, 3'(cur_idx_ff), 24'd0, 7'd0};
               state_in = S_EMIT;
            end else begin
               state_in = S_BUDGET;
            end
         end

         // Duplicate id: digest must agree
         S_DIGCMP: begin
            if (dig_rd_ff != itm_ff.payload_digest) begin
               valid_in[cur_idx_ff] = 1'b0;
               used_in  = sat_sub(used_ff, cur_ff.bytes);
               res_in   = '{frt_pkg::ST_CONFLICT, 3'(cur_idx_ff), 24'd0, 7'd0};
               state_in = S_EMIT;
            end else begin
               state_in = S_FINISH;
            end
         end

         S_BUDGET: begin
            if (({1'b0, used_ff} + {9'd0, itm_ff.payload_len}) > {1'b0, cfg.reassembly_budget})
               begin
               rd_idx_in  = '0;
               old_fnd_in = 1'b0;
               state_in   = S_BSCAN;
            end else begin
               cur_in.present[fidx] = 1'b1;
               cur_in.cnt   = cur_ff.cnt + CW'(1);
               cur_in.maxid = (fidx > cur_ff.maxid) ? fidx : cur_ff.maxid;
               cur_in.bytes = sum[23:0];
               used_in      = 24'({1'b0, used_ff} + {9'd0, itm_ff.payload_len});
               dig_we       = 1'b1;
               state_in     = S_FINISH;
            end
         end

         // Oldest other slot for eviction
         S_BSCAN: begin
            if (pv_ff) begin
               v = valid_ff[pidx_ff] && (pidx_ff != cur_idx_ff);
               if (v && (!old_fnd_ff || age > old_age_ff)) begin
                  old_fnd_in   = 1'b1;
                  old_idx_in   = pidx_ff;
                  old_age_in   = age;
                  old_bytes_in = r.bytes;
               end
               if (pidx_ff == LAST) state_in = S_BDEC;
            end
         end

         S_BDEC: begin
            if (!old_fnd_ff) begin
               valid_in[cur_idx_ff] = 1'b0;
               used_in  = sat_sub(used_ff, cur_ff.bytes);
               res_in   = '{frt_pkg::ST_NOSPACE, 3'(cur_idx_ff), 24'd0, 7'd0};
               state_in = S_EMIT;
            end else begin
               valid_in[old_idx_ff] = 1'b0;
               used_in  = sat_sub(used_ff, old_bytes_ff);
               state_in = S_BUDGET;
            end
         end

         // Completion when ids run 0..n-1 and bytes reach the total
         S_FINISH: begin
            if ((CW'(cur_ff.maxid) + CW'(1) == cur_ff.cnt) && (cur_ff.bytes == cur_ff.total)) begin
               valid_in[cur_idx_ff] = 1'b0;
               used_in  = sat_sub(used_ff, cur_ff.bytes);
               res_in   = '{frt_pkg::ST_COMPLETE, 3'(cur_idx_ff), cur_ff.total, 7'(cur_ff.cnt)};
            end else begin
               mem_we         = 1'b1;
               mem_wd.updated = time_ff;
               res_in   = '{frt_pkg::ST_PENDING, 3'(cur_idx_ff), 24'd0, 7'd0};
            end
            state_in = S_EMIT;
         end

         S_EMIT: begin
            if (res_ready) state_in = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         used_ff  <= 24'd0;
         time_ff  <= 32'd0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         used_ff  <= used_in;
         time_ff  <= time_in;
         pv_ff    <= pv_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      itm_ff       <= itm_in;
      res_ff       <= res_in;
      cur_ff       <= cur_in;
      cur_idx_ff   <= cur_idx_in;
      rd_idx_ff    <= rd_idx_in;
      pidx_ff      <= pidx_in;
      match_fnd_ff <= match_fnd_in;
      free_fnd_ff  <= free_fnd_in;
      free_idx_ff  <= free_idx_in;
      old_fnd_ff   <= old_fnd_in;
      old_idx_ff   <= old_idx_in;
      old_age_ff   <= old_age_in;
      old_bytes_ff <= old_bytes_in;
   end

   // Slot record memory
   always_ff @(posedge clock) begin
      if (mem_we) slot_mem[cur_idx_ff] <= mem_wd;
      if (mem_re) mem_rd_ff <= slot_mem[mem_ra];
   end

   // Digest memory
   always_ff @(posedge clock) begin
      if (dig_we) dig_mem[dig_addr] <= itm_ff.payload_digest;
      if (dig_re) dig_rd_ff <= dig_mem[dig_addr];
   end

`ifndef ASSERT_OFF
   a_check_slot_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> valid_ff[cur_idx_ff])
      else $error("slot not live at fragment check");

   a_complete_freed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && res_ff.status == frt_pkg::ST_COMPLETE) |-> !valid_ff[cur_idx_ff])
      else $error("completed slot still held");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_BSCAN) |-> (rd_idx_ff <= SCW'(SLOTS)))
      else $error("scan index past slot count");

   a_tick_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req.cmd == frt_pkg::CMD_TICK)
      |=> (time_ff == $past(time_ff) + 32'd1))
      else $error("tick did not advance time");
`endif

endmodule
`default_nettype wire
